[rtl/bdq_pkg.sv]
// Shared types and constants for the byte deque with remove-by-value.
// No dependencies; used by byte_deque_with_value_remove only.
package bdq_pkg;

   localparam int DEPTH = 16;                  // entries in the store, 2..31
   localparam int AW    = $clog2(DEPTH);       // store address width
   localparam int CW    = $clog2(DEPTH + 1);   // fill count width

   typedef logic [AW-1:0] addr_type;
   typedef logic [CW-1:0] cnt_type;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REMOVE     = 3'd4,
      OP_CONTAINS   = 3'd5,
      OP_PEEK_FRONT = 3'd6,
      OP_PEEK_BACK  = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_READ = 2'd1,
      S_SCAN = 2'd2,
      S_MOVE = 2'd3
   } state_type;

   // Map a position counted from the front to a physical store address.
   function automatic addr_type phys_addr(input addr_type head, input cnt_type pos);
      logic [CW:0] sum;
      sum = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, pos};
      if (sum >= (CW + 1)'(DEPTH)) begin
         sum = sum - (CW + 1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   function automatic addr_type addr_inc(input addr_type a);
      return (a == AW'(DEPTH - 1)) ? '0 : AW'(a + 1'b1);
   endfunction

   function automatic addr_type addr_dec(input addr_type a);
      return (a == '0) ? AW'(DEPTH - 1) : AW'(a - 1'b1);
   endfunction

endpackage

[rtl/bdq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependencies.
module bdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/byte_deque_with_value_remove.sv]
// Byte deque, DEPTH entries, kept as a circular buffer in one synchronous RAM.
// Pushes and any request on an empty queue load the result as they are accepted; a pop
// or peek first reads the RAM (S_READ). Contains and remove walk the store from the
// front at one entry per cycle, then a remove shifts the tail down one entry per cycle.
// One item in flight; the next is taken as the result leaves.
// Reset clears head pointer, fill count, result valid and FSM; the store is never cleared.
module byte_deque_with_value_remove (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_in
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] data_out, [9:8] status,
                                    // [14:10] fill_count, [15] is_empty
);

   // Controller state
   bdq_pkg::state_type state_ff, state_in;
   bdq_pkg::addr_type  head_ff, head_in;      // physical address of the front
   bdq_pkg::cnt_type   occ_ff, occ_in;        // bytes held
   bdq_pkg::cnt_type   idx_ff, idx_in;        // scan / shift position from front
   bdq_pkg::op_type    op_ff, op_in;
   logic [7:0]         val_ff, val_in;

   // Result register
   logic               rsp_valid_ff;
   logic [7:0]         rsp_data_ff;
   logic [1:0]         rsp_status_ff;
   logic [4:0]         rsp_fill_ff;
   logic               rsp_empty_ff;

   // RAM port
   logic               ram_we;
   bdq_pkg::addr_type  ram_wr_addr;
   logic [7:0]         ram_wr_data;
   bdq_pkg::addr_type  ram_rd_addr;
   logic [7:0]         ram_rd_data;

   // Result load
   logic               rsp_load;
   logic [7:0]         res_data;
   bdq_pkg::status_type res_status;

   // Decode helpers
   bdq_pkg::op_type    req_op;
   logic               req_acc;
   logic               out_free;
   logic               is_full;
   logic               is_empty_now;
   bdq_pkg::cnt_type   occ_last;
   logic               scan_match;
   logic               scan_last;
   logic               move_last;

   assign req_op       = bdq_pkg::op_type'(req_tuser);
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (state_ff == bdq_pkg::S_IDLE) && out_free;
   assign req_acc      = req_tvalid && req_tready;
   assign is_full      = (occ_ff == bdq_pkg::CW'(bdq_pkg::DEPTH));
   assign is_empty_now = (occ_ff == '0);
   assign occ_last     = bdq_pkg::CW'(occ_ff - 1'b1);
   assign scan_match   = (ram_rd_data == val_ff);
   assign scan_last    = (idx_ff == occ_last);
   assign move_last    = (bdq_pkg::CW'(idx_ff + 1'b1) == occ_last);

   bdq_ram #(
      .WIDTH (8),
      .DEPTH (bdq_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdq_pkg::S_IDLE: begin
            if (req_acc) begin
               case (req_op)
                  bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK,
                  bdq_pkg::OP_PEEK_FRONT, bdq_pkg::OP_PEEK_BACK: begin
                     if (!is_empty_now) state_in = bdq_pkg::S_READ;
                  end
                  bdq_pkg::OP_REMOVE, bdq_pkg::OP_CONTAINS: begin
                     if (!is_empty_now) state_in = bdq_pkg::S_SCAN;
                  end
                  default: state_in = bdq_pkg::S_IDLE;
               endcase
            end
         end
         bdq_pkg::S_READ: state_in = bdq_pkg::S_IDLE;
         bdq_pkg::S_SCAN: begin
            if (scan_match) begin
               if (op_ff == bdq_pkg::OP_CONTAINS || scan_last) begin
                  state_in = bdq_pkg::S_IDLE;
               end else begin
                  state_in = bdq_pkg::S_MOVE;
               end
            end else if (scan_last) begin
               state_in = bdq_pkg::S_IDLE;
            end
         end
         bdq_pkg::S_MOVE: begin
            if (move_last) state_in = bdq_pkg::S_IDLE;
         end
         default: state_in = bdq_pkg::S_IDLE;
      endcase
   end

   // Datapath control
   always_comb begin
      head_in     = head_ff;
      occ_in      = occ_ff;
      idx_in      = idx_ff;
      op_in       = op_ff;
      val_in      = val_ff;
      ram_we      = 1'b0;
      ram_wr_addr = bdq_pkg::phys_addr(head_ff, idx_ff);
      ram_wr_data = ram_rd_data;
      ram_rd_addr = bdq_pkg::phys_addr(head_ff, '0);
      rsp_load    = 1'b0;
      res_data    = '0;
      res_status  = bdq_pkg::ST_OK;
      case (state_ff)
         bdq_pkg::S_IDLE: begin
            if (req_acc) begin
               op_in  = req_op;
               val_in = req_tdata;
               idx_in = '0;
               case (req_op)
                  bdq_pkg::OP_PUSH_FRONT: begin
                     rsp_load = 1'b1;
                     if (is_full) begin
                        res_status = bdq_pkg::ST_FULL;
                     end else begin
                        // grow the buffer backward from the head
                        head_in     = bdq_pkg::addr_dec(head_ff);
                        ram_we      = 1'b1;
                        ram_wr_addr = bdq_pkg::addr_dec(head_ff);
                        ram_wr_data = req_tdata;
                        occ_in      = bdq_pkg::CW'(occ_ff + 1'b1);
                     end
                  end
                  bdq_pkg::OP_PUSH_BACK: begin
                     rsp_load = 1'b1;
                     if (is_full) begin
                        res_status = bdq_pkg::ST_FULL;
                     end else begin
                        ram_we      = 1'b1;
                        ram_wr_addr = bdq_pkg::phys_addr(head_ff, occ_ff);
                        ram_wr_data = req_tdata;
                        occ_in      = bdq_pkg::CW'(occ_ff + 1'b1);
                     end
                  end
                  bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_PEEK_FRONT: begin
                     if (is_empty_now) begin
                        rsp_load   = 1'b1;
                        res_status = bdq_pkg::ST_EMPTY;
                     end else begin
                        ram_rd_addr = bdq_pkg::phys_addr(head_ff, '0);
                        if (req_op == bdq_pkg::OP_POP_FRONT) begin
                           head_in = bdq_pkg::addr_inc(head_ff);
                           occ_in  = occ_last;
                        end
                     end
                  end
                  bdq_pkg::OP_POP_BACK, bdq_pkg::OP_PEEK_BACK: begin
                     if (is_empty_now) begin
                        rsp_load   = 1'b1;
                        res_status = bdq_pkg::ST_EMPTY;
                     end else begin
                        ram_rd_addr = bdq_pkg::phys_addr(head_ff, occ_last);
                        if (req_op == bdq_pkg::OP_POP_BACK) begin
                           occ_in = occ_last;
                        end
                     end
                  end
                  default: begin
                     // remove or contains: start the walk at the front
                     if (is_empty_now) begin
                        rsp_load   = 1'b1;
                        res_status = bdq_pkg::ST_NOT_FOUND;
                     end else begin
                        ram_rd_addr = bdq_pkg::phys_addr(head_ff, '0);
                     end
                  end
               endcase
            end
         end
         bdq_pkg::S_READ: begin
            rsp_load = 1'b1;
            res_data = ram_rd_data;
         end
         bdq_pkg::S_SCAN: begin
            if (scan_match) begin
               if (op_ff == bdq_pkg::OP_CONTAINS) begin
                  rsp_load = 1'b1;
               end else if (scan_last) begin
                  // match at the back: just drop it
                  rsp_load = 1'b1;
                  occ_in   = occ_last;
               end else begin
                  ram_rd_addr = bdq_pkg::phys_addr(head_ff, bdq_pkg::CW'(idx_ff + 1'b1));
               end
            end else if (scan_last) begin
               rsp_load   = 1'b1;
               res_status = bdq_pkg::ST_NOT_FOUND;
            end else begin
               idx_in      = bdq_pkg::CW'(idx_ff + 1'b1);
               ram_rd_addr = bdq_pkg::phys_addr(head_ff, bdq_pkg::CW'(idx_ff + 1'b1));
            end
         end
         bdq_pkg::S_MOVE: begin
            // read data is entry idx+1; write it one slot toward the front
            ram_we      = 1'b1;
            ram_wr_addr = bdq_pkg::phys_addr(head_ff, idx_ff);
            ram_wr_data = ram_rd_data;
            if (move_last) begin
               rsp_load = 1'b1;
               occ_in   = occ_last;
            end else begin
               idx_in      = bdq_pkg::CW'(idx_ff + 1'b1);
               ram_rd_addr = bdq_pkg::phys_addr(head_ff, bdq_pkg::CW'(idx_ff + 2'd2));
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      op_ff  <= op_in;
      val_ff <= val_in;
      if (rsp_load) begin
         rsp_data_ff   <= res_data;
         rsp_status_ff <= res_status;
         rsp_fill_ff   <= 5'(occ_in);
         rsp_empty_ff  <= (occ_in == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_empty_ff, rsp_fill_ff, rsp_status_ff, rsp_data_ff};

   // Checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= bdq_pkg::CW'(bdq_pkg::DEPTH))
      else $error("fill count above depth");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded over an untaken result");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_op == bdq_pkg::OP_PUSH_BACK || req_op == bdq_pkg::OP_PUSH_FRONT)
       && !is_full) |=> (occ_ff == bdq_pkg::CW'($past(occ_ff) + 1'b1)))
      else $error("push did not grow the queue");

   a_move_no_clash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdq_pkg::S_MOVE && !move_last) |-> (ram_wr_addr != ram_rd_addr))
      else $error("shift reads the entry it writes");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= bdq_pkg::AW'(bdq_pkg::DEPTH - 1))
      else $error("head pointer out of range");

endmodule
